FILE: rtl/core/btnhc_pkg.sv
`default_nettype none
package btnhc_pkg;

    localparam int HOLD_SHUTDOWN_MS_DEF = 2000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_READY_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_STAMP_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_IGNORE_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX_MS   = 3'd4;

    localparam logic [15:0] BOOT_IGNORE_RST = 16'd800;
    localparam logic [15:0] CLICK_MIN_RST   = 16'd30;
    localparam logic [15:0] CLICK_MAX_RST   = 16'd800;

    localparam logic [2:0] LIT_MAX = 3'd4;

endpackage
`default_nettype wire

FILE: rtl/core/btnhc_if.sv
`default_nettype none
interface btnhc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        key_down;

    modport source (output valid, output now_ms, output key_down, input ready);
    modport sink   (input valid, input now_ms, input key_down, output ready);
endinterface

interface btnhc_out_if;
    logic       valid;
    logic       ready;
    logic       flow_on;
    logic       show_progress;
    logic [2:0] progress_lit;
    logic       beep_pulse;
    logic       toggle_pulse;
    logic       shutdown_pulse;

    modport source (output valid, output flow_on, output show_progress,
                    output progress_lit, output beep_pulse, output toggle_pulse,
                    output shutdown_pulse, input ready);
    modport sink   (input valid, input flow_on, input show_progress,
                    input progress_lit, input beep_pulse, input toggle_pulse,
                    input shutdown_pulse, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/button_hold_click_classifier.sv
// button_hold_click_classifier
// in_ch carries one poll per item: a millisecond timestamp and the debounced
// key level. out_ch returns exactly one result item per poll, in order: flow
// state, hold progress with its beep pulse, click toggle and shutdown pulse.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce
// it, and an index beyond the register list is dropped. An accepted poll is
// held in an input register, classified against the key state by compare and
// subtract logic, and written to the result register when that is free.
// Unstalled throughput is one poll per cycle, set by the single classify stage.
// When the receiver stalls, the result register holds; the input register
// still takes one more poll, then in_ch.ready falls until out_ch moves.
// Reset clears the key state, loads the register defaults and empties both
// registers. After a shutdown pulse the block stays inert until reset.
`default_nettype none
module button_hold_click_classifier
    import btnhc_pkg::*;
#(
    parameter int HOLD_SHUTDOWN_MS = HOLD_SHUTDOWN_MS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    btnhc_in_if.sink                   in_ch,
    btnhc_out_if.source                out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [31:0] HOLD_T  = 32'(HOLD_SHUTDOWN_MS);
    localparam logic [31:0] LIT1_T  = 32'((1 * HOLD_SHUTDOWN_MS + 3) / 4);
    localparam logic [31:0] LIT2_T  = 32'((2 * HOLD_SHUTDOWN_MS + 3) / 4);
    localparam logic [31:0] LIT3_T  = 32'((3 * HOLD_SHUTDOWN_MS + 3) / 4);
    localparam logic [31:0] LIT4_T  = 32'((4 * HOLD_SHUTDOWN_MS + 3) / 4);

    // configuration
    logic        ready_enable_reg;
    logic [31:0] ready_stamp_reg;
    logic [15:0] boot_ignore_reg;
    logic [15:0] click_min_reg;
    logic [15:0] click_max_reg;

    // key state
    logic        pressing_reg, pressing_next;
    logic [31:0] press_stamp_reg, press_stamp_next;
    logic        flow_stop_reg, flow_stop_next;
    logic [2:0]  last_lit_reg, last_lit_next;
    logic        halted_reg, halted_next;

    // input stage
    logic        s1_valid_reg;
    logic [31:0] s1_now_reg;
    logic        s1_key_reg;

    // result stage
    logic        r_valid_reg;
    logic        r_flow_reg, r_show_reg, r_beep_reg, r_toggle_reg, r_shut_reg;
    logic [2:0]  r_lit_reg;

    logic        advance;
    logic        active;
    logic [31:0] since_ready, held;
    logic [2:0]  lit;
    logic        show, beep, toggle, shut;

    assign advance      = s1_valid_reg && (!r_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_enable_reg <= 1'b0;
            ready_stamp_reg  <= '0;
            boot_ignore_reg  <= BOOT_IGNORE_RST;
            click_min_reg    <= CLICK_MIN_RST;
            click_max_reg    <= CLICK_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_READY_ENABLE:   ready_enable_reg <= cfg_wdata[0];
                CFG_READY_STAMP_MS: ready_stamp_reg  <= cfg_wdata[31:0];
                CFG_BOOT_IGNORE_MS: boot_ignore_reg  <= cfg_wdata[15:0];
                CFG_CLICK_MIN_MS:   click_min_reg    <= cfg_wdata[15:0];
                CFG_CLICK_MAX_MS:   click_max_reg    <= cfg_wdata[15:0];
                default:            ;
            endcase
        end
    end

    assign since_ready = s1_now_reg - ready_stamp_reg;
    assign held        = s1_now_reg - press_stamp_reg;
    assign active      = !halted_reg && ready_enable_reg &&
                         (since_ready >= {16'd0, boot_ignore_reg});

    always_comb
    begin
        lit = 3'd0;
        if (held >= LIT4_T)
        begin
            lit = LIT_MAX;
        end
        else if (held >= LIT3_T)
        begin
            lit = 3'd3;
        end
        else if (held >= LIT2_T)
        begin
            lit = 3'd2;
        end
        else if (held >= LIT1_T)
        begin
            lit = 3'd1;
        end
    end

    always_comb
    begin
        pressing_next    = pressing_reg;
        press_stamp_next = press_stamp_reg;
        flow_stop_next   = flow_stop_reg;
        last_lit_next    = last_lit_reg;
        halted_next      = halted_reg;
        show   = 1'b0;
        beep   = 1'b0;
        toggle = 1'b0;
        shut   = 1'b0;
        if (active)
        begin
            if (s1_key_reg)
            begin
                if (!pressing_reg)
                begin
                    // first poll of a press
                    pressing_next    = 1'b1;
                    press_stamp_next = s1_now_reg;
                    last_lit_next    = 3'd0;
                    flow_stop_next   = 1'b1;
                end
                else
                begin
                    show = 1'b1;
                    if (lit > last_lit_reg)
                    begin
                        beep          = 1'b1;
                        last_lit_next = lit;
                    end
                    if (held >= HOLD_T)
                    begin
                        shut        = 1'b1;
                        halted_next = 1'b1;
                    end
                end
            end
            else if (pressing_reg)
            begin
                toggle = (held > {16'd0, click_min_reg}) &&
                         (held < {16'd0, click_max_reg});
                flow_stop_next   = 1'b0;
                pressing_next    = 1'b0;
                last_lit_next    = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressing_reg    <= 1'b0;
            press_stamp_reg <= '0;
            flow_stop_reg   <= 1'b0;
            last_lit_reg    <= 3'd0;
            halted_reg      <= 1'b0;
            s1_valid_reg    <= 1'b0;
            r_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                pressing_reg    <= pressing_next;
                press_stamp_reg <= press_stamp_next;
                flow_stop_reg   <= flow_stop_next;
                last_lit_reg    <= last_lit_next;
                halted_reg      <= halted_next;
                r_valid_reg     <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                r_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_now_reg <= in_ch.now_ms;
            s1_key_reg <= in_ch.key_down;
        end
        if (advance)
        begin
            r_flow_reg   <= !flow_stop_next && !halted_next;
            r_show_reg   <= show;
            r_lit_reg    <= show ? lit : 3'd0;
            r_beep_reg   <= beep;
            r_toggle_reg <= toggle;
            r_shut_reg   <= shut;
        end
    end

    assign out_ch.valid          = r_valid_reg;
    assign out_ch.flow_on        = r_flow_reg;
    assign out_ch.show_progress  = r_show_reg;
    assign out_ch.progress_lit   = r_lit_reg;
    assign out_ch.beep_pulse     = r_beep_reg;
    assign out_ch.toggle_pulse   = r_toggle_reg;
    assign out_ch.shutdown_pulse = r_shut_reg;

endmodule
`default_nettype wire
